FILE: hw/rtl/itw_pkg.sv
package itw_pkg;

    // Input and token widths
    localparam int VALUE_W    = 32;
    localparam int WORD_W     = 6;

    // Binary to BCD conversion: two bits per cycle, ten decimal digits
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(CONV_STEPS);
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int NUM_GROUPS    = 4;
    localparam int GRP_BCD_W     = 12 * NUM_GROUPS;

    // Token slots: one lead slot, then five per group (digit, Hundred, tens, ones, scale)
    localparam int SLOTS_PER_GRP = 5;
    localparam int NUM_SLOTS     = 1 + SLOTS_PER_GRP * NUM_GROUPS;
    localparam int SLOT_IDX_W    = $clog2(NUM_SLOTS);

    // Token codes
    localparam logic [WORD_W-1:0] TOK_ZERO     = 6'd0;
    localparam logic [WORD_W-1:0] TOK_TEN      = 6'd10;
    localparam logic [WORD_W-1:0] TOK_TENS_OFS = 6'd18;
    localparam logic [WORD_W-1:0] TOK_HUNDRED  = 6'd28;
    localparam logic [WORD_W-1:0] TOK_THOUSAND = 6'd29;
    localparam logic [WORD_W-1:0] TOK_NEGATIVE = 6'd32;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SLOTS,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic prep;
        logic emit;
    } t_ctl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

FILE: hw/rtl/itw_ctrl.sv
module itw_ctrl import itw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd,
    output logic       o_busy
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CONV_STEPS - 1)) begin
                    n_state = ST_SLOTS;
                end
            end
            ST_SLOTS: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    // Checks
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.step, o_cmd.prep, o_cmd.emit}))
        else $error("more than one datapath command at once");

    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_cnt == CNT_W'(CONV_STEPS - 1)) |=> r_state == ST_SLOTS)
        else $error("conversion did not end after its step count");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_status.last) |=> r_state == ST_EMIT)
        else $error("token run left before its last token");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(o_cmd.emit && i_status.last))
        else $error("busy dropped without a last token");

endmodule

FILE: hw/rtl/itw_dpath.sv
module itw_dpath import itw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VALUE_W-1:0] i_value,
    input  t_ctl_cmd           i_cmd,
    output t_dp_status         o_status,
    output logic [WORD_W-1:0]  o_word,
    output logic               o_last,
    output logic               o_valid
);

    logic [VALUE_W-1:0]   r_mag;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic                 r_neg;
    logic                 r_zero;
    logic [NUM_SLOTS-1:0] r_pres;
    logic [WORD_W-1:0]    r_word;
    logic                 r_last;
    logic                 r_valid;

    logic [GRP_BCD_W-1:0] grp_bcd;
    logic [WORD_W-1:0]    slot_tok [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_pres;
    logic [NUM_SLOTS-1:0] low_bit;
    logic [SLOT_IDX_W-1:0] low_idx;
    logic                 last_tok;

    // One double-dabble bit: add 3 to digits of 5 or more, then shift in
    function automatic logic [BCD_W-1:0] f_dd_bit(input logic [BCD_W-1:0] bcd,
                                                  input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (adj[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    assign n_bcd = f_dd_bit(f_dd_bit(r_bcd, r_mag[VALUE_W-1]), r_mag[VALUE_W-2]);

    // Load magnitude, convert to BCD two bits per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[VALUE_W-1];
            r_zero <= (i_value == '0);
            r_mag  <= i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            r_bcd  <= '0;
        end else if (i_cmd.step) begin
            r_mag  <= {r_mag[VALUE_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
            r_bcd  <= n_bcd;
        end
    end

    assign grp_bcd = {(GRP_BCD_W - BCD_W)'(0), r_bcd};

    // Token and presence per slot, most significant first
    always_comb begin
        logic [3:0] h, t, o;
        int         base;
        slot_tok[0]  = r_neg ? TOK_NEGATIVE : TOK_ZERO;
        slot_pres[0] = r_neg | r_zero;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            h    = grp_bcd[12*g+8 +: 4];
            t    = grp_bcd[12*g+4 +: 4];
            o    = grp_bcd[12*g   +: 4];
            base = 1 + SLOTS_PER_GRP * (NUM_GROUPS - 1 - g);
            // hundreds digit and Hundred
            slot_tok[base]    = {2'b00, h};
            slot_pres[base]   = (h != 4'd0);
            slot_tok[base+1]  = TOK_HUNDRED;
            slot_pres[base+1] = (h != 4'd0);
            // tens word, teens word or lone ones word
            if (t >= 4'd2) begin
                slot_tok[base+2] = TOK_TENS_OFS + {2'b00, t};
            end else if (t == 4'd1) begin
                slot_tok[base+2] = TOK_TEN + {2'b00, o};
            end else begin
                slot_tok[base+2] = {2'b00, o};
            end
            slot_pres[base+2] = (t != 4'd0) || (o != 4'd0);
            // ones word after a tens word
            slot_tok[base+3]  = {2'b00, o};
            slot_pres[base+3] = (t >= 4'd2) && (o != 4'd0);
            // Thousand, Million or Billion
            slot_tok[base+4]  = TOK_HUNDRED + WORD_W'(g);
            slot_pres[base+4] = (g != 0) && ((h != 4'd0) || (t != 4'd0) || (o != 4'd0));
        end
    end

    // Next pending slot
    assign low_bit  = r_pres & (~r_pres + 1'b1);
    assign last_tok = ((r_pres & ~low_bit) == '0);

    always_comb begin
        low_idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_pres[k]) begin
                low_idx = SLOT_IDX_W'(k);
            end
        end
    end

    assign o_status.last = last_tok;

    // Slot mask
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_pres <= slot_pres;
        end else if (i_cmd.emit) begin
            r_pres <= r_pres & ~low_bit;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_word <= slot_tok[low_idx];
            r_last <= last_tok;
        end
    end

    assign o_word  = r_word;
    assign o_last  = r_last;
    assign o_valid = r_valid;

    // Checks
    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_pres != '0)
        else $error("token emitted with no slot pending");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |=> !r_valid)
        else $error("token follows the last token of a run");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_word <= TOK_NEGATIVE)
        else $error("token code out of range");

endmodule

FILE: hw/rtl/integer_to_word_tokens.sv
// Reads a signed 32-bit integer out as English word tokens, most significant first.
// Input: drive i_value and raise start; the item is taken at a rising edge where
// start is high and busy is low. busy stays high until the last token is issued.
// Output: each token appears on o_word / o_last for one cycle with o_valid high;
// o_last marks the final token of the run. The receiver cannot stall: every
// token must be taken in the cycle it is shown.
// Operation: the magnitude goes through a double-dabble BCD converter that handles
// two bits per cycle, a slot state then builds the token slot mask, and one
// token is issued per cycle after that. A new item is not taken until busy
// falls after the last token of a run; an item has 1 to 17 tokens.
// Reset (synchronous, active low) returns the controller to idle and clears
// o_valid; any run in progress is dropped.
module integer_to_word_tokens import itw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    output logic [WORD_W-1:0]  o_word,
    output logic               o_last,
    output logic               o_valid
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    // Sequencer
    itw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Conversion and token datapath
    itw_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_cmd    (cmd),
        .o_status (status),
        .o_word   (o_word),
        .o_last   (o_last),
        .o_valid  (o_valid)
    );

endmodule

FILE: verif/integer_to_word_tokens_test.sv
`timescale 1ns / 100ps

module integer_to_word_tokens_test import itw_pkg::*;;

    // Token codes not named in the package
    localparam logic [WORD_W-1:0] W_ONE     = 6'd1;
    localparam logic [WORD_W-1:0] W_TWO     = 6'd2;
    localparam logic [WORD_W-1:0] W_THREE   = 6'd3;
    localparam logic [WORD_W-1:0] W_FOUR    = 6'd4;
    localparam logic [WORD_W-1:0] W_SIX     = 6'd6;
    localparam logic [WORD_W-1:0] W_SEVEN   = 6'd7;
    localparam logic [WORD_W-1:0] W_EIGHT   = 6'd8;
    localparam logic [WORD_W-1:0] W_FORTY   = TOK_TENS_OFS + 6'd4;
    localparam logic [WORD_W-1:0] W_EIGHTY  = TOK_TENS_OFS + 6'd8;
    localparam logic [WORD_W-1:0] W_MILLION = TOK_THOUSAND + 6'd1;
    localparam logic [WORD_W-1:0] W_BILLION = TOK_THOUSAND + 6'd2;

    localparam int MAX_WORDS    = 17;
    localparam int WORDS_W      = MAX_WORDS * WORD_W;
    localparam int NUM_RANDOM   = 156;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_ROWS     = 24;

    // One token as seen on the output
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_token;

    // Directed row: words typed right-justified, last token in element 0;
    // count of zero means the reading comes from the predictor
    typedef struct packed {
        logic [VALUE_W-1:0]                 value;
        logic [4:0]                         count;
        logic [MAX_WORDS-1:0][WORD_W-1:0]   words;
    } t_reading_row;

    localparam t_reading_row READING_ROWS [NUM_ROWS] = '{
        '{32'd0,          5'd1,  WORDS_W'({TOK_ZERO})},
        '{32'd1,          5'd1,  WORDS_W'({W_ONE})},
        '{-32'sd1,        5'd2,  WORDS_W'({TOK_NEGATIVE, W_ONE})},
        '{32'd2147483647, 5'd16, WORDS_W'({W_TWO, W_BILLION, W_ONE, TOK_HUNDRED, W_FORTY,
                                  W_SEVEN, W_MILLION, W_FOUR, TOK_HUNDRED, W_EIGHTY,
                                  W_THREE, TOK_THOUSAND, W_SIX, TOK_HUNDRED, W_FORTY,
                                  W_SEVEN})},
        '{32'h8000_0000,  5'd17, WORDS_W'({TOK_NEGATIVE, W_TWO, W_BILLION, W_ONE,
                                  TOK_HUNDRED, W_FORTY, W_SEVEN, W_MILLION, W_FOUR,
                                  TOK_HUNDRED, W_EIGHTY, W_THREE, TOK_THOUSAND, W_SIX,
                                  TOK_HUNDRED, W_FORTY, W_EIGHT})},
        '{32'h8000_0001,  5'd0,  '0},
        '{32'd1000,       5'd2,  WORDS_W'({W_ONE, TOK_THOUSAND})},
        '{32'd1000000,    5'd2,  WORDS_W'({W_ONE, W_MILLION})},
        '{32'd1000000000, 5'd2,  WORDS_W'({W_ONE, W_BILLION})},
        '{32'd10,         5'd0,  '0},
        '{32'd19,         5'd0,  '0},
        '{32'd20,         5'd0,  '0},
        '{32'd99,         5'd0,  '0},
        '{32'd100,        5'd0,  '0},
        '{32'd110,        5'd0,  '0},
        '{32'd999,        5'd0,  '0},
        '{32'd1011121314, 5'd0,  '0},
        '{32'd1617181920, 5'd0,  '0},
        '{32'd304050607,  5'd0,  '0},
        '{32'd1000001000, 5'd0,  '0},
        '{-32'sd999999999, 5'd0, '0},
        '{32'd2000000000, 5'd0,  '0},
        '{32'd70080,      5'd0,  '0},
        '{32'd555000,     5'd0,  '0}
    };

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               busy;
    logic [WORD_W-1:0]  o_word;
    logic               o_last;
    logic               o_valid;

    t_token expected_tokens [$];
    int     error_count = 0;
    int     burst_left;

    integer_to_word_tokens u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_value (i_value),
        .o_word  (o_word),
        .o_last  (o_last),
        .o_valid (o_valid)
    );

    always #5 i_clk = ~i_clk;

    // Append one expected token
    function automatic void add_token(logic [WORD_W-1:0] w, logic is_last);
        t_token tok;
        tok.word = w;
        tok.last = is_last;
        expected_tokens = {expected_tokens, tok};
    endfunction

    // Reading predictor
    function automatic void queue_word(logic [WORD_W-1:0] w);
        add_token(w, 1'b0);
    endfunction

    // One three-digit group: hundreds, then tens/ones, teens or a single ones word
    function automatic void predict_group(int unsigned grp);
        int unsigned hundreds;
        int unsigned rest;
        hundreds = grp / 100;
        rest     = grp % 100;
        if (hundreds != 0) begin
            queue_word(WORD_W'(hundreds));
            queue_word(TOK_HUNDRED);
        end
        if (rest >= 20) begin
            queue_word(TOK_TENS_OFS + WORD_W'(rest / 10));
            if (rest % 10 != 0)
                queue_word(WORD_W'(rest % 10));
        end else if (rest >= 10) begin
            queue_word(TOK_TEN + WORD_W'(rest - 10));
        end else if (rest > 0) begin
            queue_word(WORD_W'(rest));
        end
    endfunction

    function automatic void predict_reading(logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        int unsigned        remaining;
        int unsigned        groups [4];
        if (value == '0) begin
            queue_word(TOK_ZERO);
        end else begin
            magnitude = value;
            if (value[VALUE_W-1]) begin
                queue_word(TOK_NEGATIVE);
                magnitude = -value;
            end
            remaining = magnitude;
            for (int g = 0; g < 4; g++) begin
                groups[g] = remaining % 1000;
                remaining = remaining / 1000;
            end
            for (int g = 3; g >= 0; g--) begin
                if (groups[g] != 0) begin
                    predict_group(groups[g]);
                    case (g)
                        1: queue_word(TOK_THOUSAND);
                        2: queue_word(W_MILLION);
                        3: queue_word(W_BILLION);
                        default: ;
                    endcase
                end
            end
        end
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    // Random values: raw words, small numbers, numbers built from sparse groups,
    // and values close to the ends of the range or on a scale boundary
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0] magnitude;
        logic        negative;
        int unsigned grp;
        negative = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: magnitude = $urandom_range(0, 999);
            2: begin
                magnitude = $urandom_range(0, 2);
                for (int g = 0; g < 3; g++) begin
                    grp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 999);
                    magnitude = magnitude * 1000 + grp;
                end
                if (magnitude > 64'd2147483648)
                    magnitude = magnitude - 64'd1000000000;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000 + $urandom_range(0, 3);
                    1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
                    2: magnitude = $urandom_range(1, 999) * 1000;
                    3: magnitude = $urandom_range(1, 999) * 1000000;
                    default: magnitude = $urandom_range(1, 2) * 1000000000;
                endcase
            end
        endcase
        if (!negative && magnitude == 64'd2147483648)
            magnitude = magnitude - 1;
        return negative ? -magnitude[VALUE_W-1:0] : magnitude[VALUE_W-1:0];
    endfunction

    // Hold start until the item is taken at an edge with busy low
    task automatic send_value(input logic [VALUE_W-1:0] value);
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Bursts of back-to-back items, then a random gap with noise on the value
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            start   <= 1'b0;
            i_value <= $urandom();
            repeat ($urandom_range(1, 40))
                @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // Token checker
    always @(posedge i_clk) begin : check_tokens
        t_token want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: word %0d last %0b", o_word, o_last);
                error_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (o_word !== want.word) begin
                    $error("word: expected %0d, actual %0d", want.word, o_word);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        logic [VALUE_W-1:0] value;
        burst_left = $urandom_range(1, 8);
        repeat (10)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        foreach (READING_ROWS[r]) begin
            send_value(READING_ROWS[r].value);
            if (READING_ROWS[r].count != 0) begin
                for (int k = int'(READING_ROWS[r].count) - 1; k >= 0; k--)
                    add_token(READING_ROWS[r].words[k], k == 0);
            end else begin
                predict_reading(READING_ROWS[r].value);
            end
            pace_sender();
        end

        // Random items
        repeat (NUM_RANDOM) begin
            value = pick_value();
            send_value(value);
            predict_reading(value);
            pace_sender();
        end
        start <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
